@@ sv/gasp_pkg.sv @@
package gasp_pkg;
  localparam int MaxGlyphs = 64;
  localparam int MaxSide = 4096;
  localparam int StartSide = 32;
  localparam int IdxW = 6;
  localparam int CntW = 7;
  localparam int SideW = 13;
  localparam int CoordW = 12;
  localparam int AccW = 14;

  typedef enum logic [8:0] {
    ST_LOAD     = 9'b0_0000_0001,
    ST_SORT_KEY = 9'b0_0000_0010,
    ST_SORT_RD  = 9'b0_0000_0100,
    ST_SORT_CMP = 9'b0_0000_1000,
    ST_SORT_WR  = 9'b0_0001_0000,
    ST_PK_RD    = 9'b0_0010_0000,
    ST_PK_WAIT  = 9'b0_0100_0000,
    ST_PK_STEP  = 9'b0_1000_0000,
    ST_PK_EMIT  = 9'b1_0000_0000
  } state_t;
endpackage

@@ sv/gasp_ram.sv @@
module gasp_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ sv/glyph_atlas_shelf_packer.sv @@
// glyph_atlas_shelf_packer
// Input channel: drive in_glyph_width, in_glyph_height and in_last_glyph with
// start high; a request is taken when start is high and busy is low. Loading
// takes one request per cycle with no result. Beyond 64 held rectangles the
// sizes are dropped, but a last mark still starts packing.
// The request marked last raises busy. The block then sorts the rectangles by
// height (stable insertion sort through one shared compare unit), then packs
// them with combinational fit adders and comparators, moving to a new shelf
// or growing the atlas where a rectangle does not fit. Each placement appears
// for one cycle with out_valid high; the receiver cannot stall the block. The
// last one carries out_last_result, and busy falls in that same cycle.
// Config: cfg_we with cfg_padding writes the padding register; the user must
// do so only while idle, which the block does not enforce. Reset (rst_n low,
// synchronous) clears the count, the sequencer and sets padding to 1;
// the size stores are not cleared.
module glyph_atlas_shelf_packer
  import gasp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [7:0]        in_glyph_width,
  input  logic [7:0]        in_glyph_height,
  input  logic              in_last_glyph,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_padding,
  output logic              out_valid,
  output logic [IdxW-1:0]   out_glyph_number,
  output logic [CoordW-1:0] out_pos_x,
  output logic [CoordW-1:0] out_pos_y,
  output logic [SideW-1:0]  out_atlas_width,
  output logic [SideW-1:0]  out_atlas_height,
  output logic              out_overflow,
  output logic              out_last_result
);
  state_t state_r, state_nxt;
  logic [3:0] pad_r;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [CntW-1:0] i_r, i_nxt;
  logic [CntW-1:0] j_r, j_nxt;
  logic [7:0] keyh_r, keyh_nxt;
  logic [AccW-1:0] x_r, x_nxt, y_r, y_nxt, xend_r, xend_nxt, xst_r, xst_nxt;
  logic [AccW-1:0] yend_r, yend_nxt, ystep_r, ystep_nxt;
  logic [SideW-1:0] wd_r, wd_nxt, ht_r, ht_nxt;
  logic ovf_r, ovf_nxt;
  logic [IdxW-1:0] g_r, g_nxt;

  // memories
  logic h_we, w_we, o_we;
  logic [IdxW-1:0] hw_waddr, h_raddr, w_raddr, o_waddr, o_raddr;
  logic [7:0] h_rdata, w_rdata;
  logic [IdxW-1:0] o_wdata, o_rdata;

  gasp_ram #(.Width(8), .Depth(MaxGlyphs)) u_h (
    .clk, .we(h_we), .waddr(hw_waddr), .wdata(in_glyph_height),
    .raddr(h_raddr), .rdata(h_rdata));
  gasp_ram #(.Width(8), .Depth(MaxGlyphs)) u_w (
    .clk, .we(w_we), .waddr(hw_waddr), .wdata(in_glyph_width),
    .raddr(w_raddr), .rdata(w_rdata));
  gasp_ram #(.Width(IdxW), .Depth(MaxGlyphs)) u_o (
    .clk, .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
    .raddr(o_raddr), .rdata(o_rdata));

  logic take;
  assign busy = (state_r != ST_LOAD);
  assign take = start && !busy;
  assign hw_waddr = cnt_r[IdxW-1:0];
  assign h_we = take && (cnt_r < CntW'(MaxGlyphs));
  assign w_we = h_we;

  // shared fit arithmetic
  logic [AccW-1:0] gwp, ghp, xa, ya, ysa, xsa;
  logic fit_x, fit_y, fit_ys, fit_xs;
  assign gwp = AccW'(w_rdata) + AccW'(pad_r);
  assign ghp = AccW'(h_rdata) + AccW'(pad_r);
  assign xa = x_r + gwp;
  assign ya = y_r + ghp;
  assign ysa = ystep_r + ghp;
  assign xsa = xst_r + gwp;
  assign fit_x = xa <= AccW'(wd_r);
  assign fit_y = ya <= AccW'(ht_r);
  assign fit_ys = ysa <= AccW'(ht_r);
  assign fit_xs = xsa <= AccW'(wd_r);

  logic [CntW-1:0] jm1, jm2, i1;
  assign jm1 = j_r - CntW'(1);
  assign jm2 = j_r - CntW'(2);
  assign i1 = i_r + CntW'(1);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    i_nxt = i_r;
    j_nxt = j_r;
    keyh_nxt = keyh_r;
    x_nxt = x_r; y_nxt = y_r; xend_nxt = xend_r; xst_nxt = xst_r;
    yend_nxt = yend_r; ystep_nxt = ystep_r;
    wd_nxt = wd_r; ht_nxt = ht_r; ovf_nxt = ovf_r; g_nxt = g_r;
    h_raddr = g_r;
    w_raddr = g_r;
    o_raddr = jm1[IdxW-1:0];
    o_we = 1'b0;
    o_waddr = j_r[IdxW-1:0];
    o_wdata = i_r[IdxW-1:0];
    unique case (state_r)
      ST_LOAD: begin
        if (take) begin
          if (cnt_r < CntW'(MaxGlyphs)) begin
            cnt_nxt = cnt_r + CntW'(1);
          end
          if (in_last_glyph) begin
            i_nxt = '0;
            j_nxt = '0;
            state_nxt = ST_SORT_WR;
          end
        end
      end
      // insertion: key = i, shift while h[o[j-1]] < h[key]
      ST_SORT_WR: begin
        o_we = 1'b1;
        if (i1 >= cnt_r) begin
          i_nxt = '0;
          x_nxt = AccW'(pad_r); y_nxt = AccW'(pad_r);
          xend_nxt = '0; xst_nxt = AccW'(pad_r);
          yend_nxt = AccW'(pad_r); ystep_nxt = '0;
          wd_nxt = SideW'(StartSide); ht_nxt = SideW'(StartSide);
          ovf_nxt = 1'b0;
          state_nxt = ST_PK_RD;
        end else begin
          i_nxt = i1;
          j_nxt = i1;
          h_raddr = i1[IdxW-1:0];
          state_nxt = ST_SORT_KEY;
        end
      end
      ST_SORT_KEY: begin
        keyh_nxt = h_rdata;
        state_nxt = ST_SORT_RD;
      end
      ST_SORT_RD: begin
        h_raddr = o_rdata;
        g_nxt = o_rdata;
        state_nxt = ST_SORT_CMP;
      end
      ST_SORT_CMP: begin
        if (h_rdata < keyh_r) begin
          o_we = 1'b1;
          o_wdata = g_r;
          j_nxt = jm1;
          if (jm1 == '0) begin
            state_nxt = ST_SORT_WR;
          end else begin
            o_raddr = jm2[IdxW-1:0];
            state_nxt = ST_SORT_RD;
          end
        end else begin
          state_nxt = ST_SORT_WR;
        end
      end
      ST_PK_RD: begin
        o_raddr = i_r[IdxW-1:0];
        state_nxt = ST_PK_WAIT;
      end
      ST_PK_WAIT: begin
        g_nxt = o_rdata;
        h_raddr = o_rdata;
        w_raddr = o_rdata;
        state_nxt = ST_PK_STEP;
      end
      ST_PK_STEP: begin
        if (ovf_r) begin
          state_nxt = ST_PK_EMIT;
        end else if (fit_x && fit_y) begin
          x_nxt = xa;
          if (ya > ystep_r) ystep_nxt = ya;
          if (xa > xend_r) xend_nxt = xa;
          if (((ya > ystep_r) ? ya : ystep_r) > yend_r) begin
            yend_nxt = (ya > ystep_r) ? ya : ystep_r;
          end
          state_nxt = ST_PK_EMIT;
        end else if (!fit_x && fit_ys && fit_xs) begin
          x_nxt = xst_r;
          y_nxt = ystep_r;
        end else if (wd_r <= ht_r) begin
          if ({wd_r, 1'b0} > (SideW + 1)'(MaxSide)) begin
            ovf_nxt = 1'b1;
          end else begin
            xst_nxt = xend_r; x_nxt = xend_r;
            y_nxt = AccW'(pad_r); ystep_nxt = AccW'(pad_r);
            wd_nxt = {wd_r[SideW-2:0], 1'b0};
          end
        end else begin
          if ({ht_r, 1'b0} > (SideW + 1)'(MaxSide)) begin
            ovf_nxt = 1'b1;
          end else begin
            x_nxt = AccW'(pad_r); xst_nxt = AccW'(pad_r);
            y_nxt = yend_r;
            ht_nxt = {ht_r[SideW-2:0], 1'b0};
          end
        end
      end
      ST_PK_EMIT: begin
        i_nxt = i1;
        if (i1 >= cnt_r) begin
          cnt_nxt = '0;
          state_nxt = ST_LOAD;
        end else begin
          o_raddr = i1[IdxW-1:0];
          state_nxt = ST_PK_WAIT;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // emitted placement: previous x/y before the advance
  logic [AccW-1:0] px_r, py_r;
  always_ff @(posedge clk) begin
    if (state_r == ST_PK_STEP && !ovf_r && fit_x && fit_y) begin
      px_r <= x_r;
      py_r <= y_r;
    end else if (state_r == ST_PK_STEP) begin
      px_r <= '0;
      py_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      pad_r <= 4'd1;
      cnt_r <= '0;
      i_r <= '0;
      j_r <= '0;
      ovf_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) pad_r <= cfg_padding;
      cnt_r <= cnt_nxt;
      i_r <= i_nxt;
      j_r <= j_nxt;
      ovf_r <= ovf_nxt;
      out_valid <= (state_r == ST_PK_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    keyh_r <= keyh_nxt;
    x_r <= x_nxt; y_r <= y_nxt; xend_r <= xend_nxt; xst_r <= xst_nxt;
    yend_r <= yend_nxt; ystep_r <= ystep_nxt;
    wd_r <= wd_nxt; ht_r <= ht_nxt; g_r <= g_nxt;
    if (state_r == ST_PK_EMIT) begin
      out_glyph_number <= g_r;
      out_pos_x <= (px_r > AccW'(4095)) ? CoordW'(4095) : px_r[CoordW-1:0];
      out_pos_y <= (py_r > AccW'(4095)) ? CoordW'(4095) : py_r[CoordW-1:0];
      out_atlas_width <= wd_r;
      out_atlas_height <= ht_r;
      out_overflow <= ovf_r;
      out_last_result <= (i1 >= cnt_r);
    end
  end
endmodule
